// ----- rtl/core/spp_pkg.sv -----
// Shared constants and types for the stable pivot partition block.
package spp_pkg;

   // Buffer for values at or above the pivot (1 .. 64 entries)
   localparam int BUFFER_DEPTH = 64;
   // Cap on results from a low final item onward: that item plus drained values
   localparam int MAX_RESULTS  = 64;

   localparam int DATA_W = 32;
   // Fill count holds 0 .. BUFFER_DEPTH
   localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
   // Buffer address
   localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FL_READ,
      ST_FL_LOAD
   } state_type;

endpackage

// ----- rtl/core/stable_pivot_partition_top.sv -----
// Stable partition of a list of signed values around a configured pivot.
//
// Input channel (req_*): one list element per item, req_final_item marks the
// last element. Result channel (rsp_*): elements in partitioned order, with
// rsp_end_of_list on the last one and a sticky rsp_overflowed flag.
// csr_wr_en / csr_wr_data write the signed pivot; write it only while idle.
// Values below the pivot come out in the cycle after they are taken, in order.
// Values at or above the pivot are stored in a 64-entry buffer memory and
// come out after the final item, in arrival order. A non-final item is taken
// whenever the output register is free. After the final item the block stalls
// its input and drains the buffer, each stored value by a read of the single
// memory port, then a load into the output register. When the buffer is full,
// further high values are dropped and the list reports overflow.
// A stalled result is held in the output register; while it waits, new
// items are not taken and the drain pauses.
// Reset (synchronous, active high) empties the buffer, clears the overflow
// flag, drops any pending result and sets the pivot to zero.
module stable_pivot_partition_top (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_wr_en,
   input  logic signed [31:0]  csr_wr_data,
   // input channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_value,
   input  logic                req_final_item,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_out_value,
   output logic                rsp_end_of_list,
   output logic                rsp_overflowed
);

   localparam int CNT_W  = spp_pkg::CNT_W;
   localparam int ADDR_W = spp_pkg::ADDR_W;
   localparam int DATA_W = spp_pkg::DATA_W;

   // state registers
   spp_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic signed [DATA_W-1:0] pivot_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] out_value_ff, out_value_in;
   logic               out_eol_ff, out_eol_in;
   logic               out_ovf_ff, out_ovf_in;
   logic               out_load;

   // buffer memory
   logic [DATA_W-1:0]  buf_mem [spp_pkg::BUFFER_DEPTH];
   logic [DATA_W-1:0]  rd_data_ff;
   logic               mem_we;
   logic               rd_en;

   logic               out_free;
   logic               is_low;
   logic               buf_full;
   logic               res_full;
   logic [CNT_W-1:0]   cnt_eff;
   logic               flush_last;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign is_low     = req_value < pivot_ff;
   assign buf_full   = int'(count_ff) >= spp_pkg::BUFFER_DEPTH;
   assign res_full   = int'(count_ff) >= spp_pkg::MAX_RESULTS;
   assign cnt_eff    = res_full ? CNT_W'(spp_pkg::MAX_RESULTS - 1) : count_ff;
   assign flush_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   // pivot register
   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_ff <= '0;
      end else if (csr_wr_en) begin
         pivot_ff <= csr_wr_data;
      end
   end

   // next state, buffer access and output loading
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_load     = 1'b0;
      out_value_in = out_value_ff;
      out_eol_in   = out_eol_ff;
      out_ovf_in   = out_ovf_ff;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      req_stall    = 1'b1;

      case (state_ff)
         spp_pkg::ST_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               if (!req_final_item) begin
                  if (is_low) begin
                     out_load     = 1'b1;
                     out_value_in = req_value;
                     out_eol_in   = 1'b0;
                     out_ovf_in   = ovf_ff;
                  end else if (!buf_full) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (is_low) begin
                  // low final item goes first; newest stored value may drop
                  out_load     = 1'b1;
                  out_value_in = req_value;
                  out_eol_in   = (cnt_eff == '0);
                  out_ovf_in   = ovf_ff || res_full;
                  if (cnt_eff == '0) begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end else begin
                     count_in = cnt_eff;
                     ovf_in   = ovf_ff || res_full;
                     idx_in   = '0;
                     state_in = spp_pkg::ST_FL_READ;
                  end
               end else begin
                  // high final item is stored if there is room, then the buffer drains
                  if (!buf_full) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  idx_in   = '0;
                  state_in = spp_pkg::ST_FL_READ;
               end
            end
         end
         spp_pkg::ST_FL_READ: begin
            rd_en    = 1'b1;
            state_in = spp_pkg::ST_FL_LOAD;
         end
         spp_pkg::ST_FL_LOAD: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_value_in = rd_data_ff;
               out_eol_in   = flush_last;
               out_ovf_in   = ovf_ff;
               if (flush_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = spp_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = spp_pkg::ST_FL_READ;
               end
            end
         end
         default: begin
            state_in = spp_pkg::ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spp_pkg::ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_eol_ff   <= out_eol_in;
      out_ovf_ff   <= out_ovf_in;
   end

   // buffer memory: write while filling, registered read while draining
   always_ff @(posedge clock) begin
      if (mem_we) begin
         buf_mem[count_ff[ADDR_W-1:0]] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= buf_mem[idx_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_end_of_list = out_eol_ff;
   assign rsp_overflowed  = out_ovf_ff;

endmodule

// ----- rtl/core/spp_checker.sv -----
// Port-level checks for the stable pivot partition block, bound to the top.
module spp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_out_value,
   input logic               rsp_end_of_list,
   input logic               rsp_overflowed
);

   // no result survives reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_value)
         && $stable(rsp_end_of_list) && $stable(rsp_overflowed))
      else $error("stalled result changed");

   // no item taken while the output register is blocked
   a_in_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("item taken while result stalled");

   // an offered item stays offered until it is taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("offered item withdrawn while stalled");

endmodule

bind stable_pivot_partition_top spp_checker u_spp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_value   (rsp_out_value),
   .rsp_end_of_list (rsp_end_of_list),
   .rsp_overflowed  (rsp_overflowed)
);
